// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VMAF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define VMAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/vmaf_pkg.sv -----
`timescale 1ns / 1ps

package vmaf_pkg;

  localparam int DATA_W     = 16;
  localparam int COEF_IDX_W = 10;
  localparam int CH_W       = 3;
  localparam int NCH_REG_W  = 4;
  localparam int ORD_REG_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_SHIFT = 14;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ORDER = 2'd1;

  localparam logic CMD_COEF   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic                     clipped;
  } mac_res_t;

endpackage

// ----- src/vmaf_if.sv -----
`timescale 1ns / 1ps

interface vmaf_in_if;
  import vmaf_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         restart;
  logic [COEF_IDX_W-1:0]        coef_index;
  logic signed [DATA_W-1:0]     coef_value;
  logic signed [DATA_W-1:0]     sample;

  modport source (output valid, cmd, restart, coef_index, coef_value, sample, input ready);
  modport sink (input valid, cmd, restart, coef_index, coef_value, sample, output ready);
endinterface

interface vmaf_out_if;
  import vmaf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filtered;
  logic [CH_W-1:0]          channel;
  logic                     vector_end;
  logic                     clipped;

  modport source (output valid, filtered, channel, vector_end, clipped, input ready);
  modport sink (input valid, filtered, channel, vector_end, clipped, output ready);
endinterface

interface vmaf_cfg_if;
  import vmaf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/vmaf_ram.sv -----
`timescale 1ns / 1ps

module vmaf_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/vmaf_mac.sv -----
`timescale 1ns / 1ps

module vmaf_mac import vmaf_pkg::*; #(
  parameter int ACC_W = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  logic signed [DATA_W-1:0] init_sample,
  input  logic                     vld,
  input  logic signed [DATA_W-1:0] hist,
  input  logic signed [DATA_W-1:0] coef,
  output logic                     busy,
  output mac_res_t                 res
);

  localparam int Y_W = ACC_W - FRAC_SHIFT;

  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_vld_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  biased;
  logic signed [Y_W-1:0]    y;
  logic                     hi;
  logic                     lo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= vld;
    end
  end

  always_ff @(posedge clk) begin
    if (vld) begin
      prod_r <= hist * coef;
    end
    if (load) begin
      acc_r <= ACC_W'(init_sample) <<< FRAC_SHIFT;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then clamp to q1.15
  always_comb begin
    biased = acc_r + ACC_W'(1 << (FRAC_SHIFT - 1));
    y      = Y_W'(biased >>> FRAC_SHIFT);
    hi     = y > Y_W'(32767);
    lo     = y < -Y_W'(32768);
    res.clipped = hi || lo;
    if (hi) begin
      res.filtered = 16'sh7fff;
    end else if (lo) begin
      res.filtered = -16'sh8000;
    end else begin
      res.filtered = DATA_W'(y);
    end
  end

  assign busy = prod_vld_r;

endmodule

// ----- src/vector_moving_average_filter.sv -----
`timescale 1ns / 1ps
// Multichannel moving-average filter. Each sample beat (cmd 1) returns one result beat:
// its own Q1.15 sample plus the coefficient-weighted sum of up to filter_order past time
// vectors, rounded and saturated. Coefficient beats (cmd 0) return nothing and keep the
// input ready. A sample beat holds off the next beat while it works through lags *
// channels history/coefficient pairs, where lags is the smaller of filter_order and the
// vectors seen since restart: one shared multiply-accumulate consumes one
// history/coefficient pair per cycle, read from the coefficient memory and the history
// ring memory; then the read, multiply and accumulate registers drain, a writeback state
// stores the result and the idle state accepts the next beat. A pass-through sample goes
// straight to writeback. Results wait in an output register; the writeback, and with it the
// next input beat, waits on the sink only while the previous result is still unaccepted.
`include "assert_macros.svh"

module vector_moving_average_filter import vmaf_pkg::*; #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_ORDER    = 16
) (
  input logic          clk,
  input logic          rst_n,
  vmaf_in_if.sink      in_bus,
  vmaf_out_if.source   out_bus,
  vmaf_cfg_if.sink     cfg_bus
);

  localparam int SLOTS     = MAX_ORDER + 1;
  localparam int RING_SIZE = SLOTS * MAX_CHANNELS;
  localparam int COEF_SIZE = MAX_CHANNELS * MAX_CHANNELS * MAX_ORDER;
  localparam int HA_W      = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
  localparam int CA_W      = (COEF_SIZE > 1) ? $clog2(COEF_SIZE) : 1;
  localparam int CNT_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W     = $clog2(MAX_CHANNELS + 1);
  localparam int ORD_W     = $clog2(MAX_ORDER + 1);
  localparam int ACC_W     = PROD_W + $clog2(MAX_ORDER * MAX_CHANNELS + 1) + 1;
  localparam logic [HA_W-1:0] LAST_BASE = HA_W'((SLOTS - 1) * MAX_CHANNELS);
  localparam logic [HA_W-1:0] CH_STEP   = HA_W'(MAX_CHANNELS);
  localparam logic [CA_W-1:0] COL_STEP  = CA_W'(MAX_CHANNELS);
  localparam logic [CA_W-1:0] LAG_STEP  = CA_W'(MAX_CHANNELS * MAX_CHANNELS);

  state_t state_r, state_nxt;

  logic [NCH_REG_W-1:0] num_channels_r;
  logic [ORD_REG_W-1:0] filter_order_r;

  logic [HA_W-1:0]  head_base_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ORD_W-1:0] vseen_r;

  logic [NCH_W-1:0]         nch_r;
  logic [ORD_W-1:0]         lags_r;
  logic [CNT_W-1:0]         row_r;
  logic                     last_r;
  logic signed [DATA_W-1:0] x_r;

  logic [CNT_W-1:0] c_r;
  logic [ORD_W-1:0] k_r;
  logic [HA_W-1:0]  hist_base_r;
  logic [CA_W-1:0]  coef_lag_r;
  logic [CA_W-1:0]  coef_addr_r;
  logic             rd_vld_r;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_filtered_r;
  logic [CH_W-1:0]          out_channel_r;
  logic                     out_end_r;
  logic                     out_clipped_r;

  logic             accept;
  logic             coef_we;
  logic             sample_go;
  logic [CNT_W-1:0] row_nxt;
  logic [ORD_W-1:0] vseen_eff;
  logic [NCH_W-1:0] nch_nxt;
  logic [ORD_W-1:0] ord_nxt;
  logic [ORD_W-1:0] lags_nxt;
  logic             last_nxt;
  logic             issue;
  logic             c_last;
  logic             k_last;
  logic             done_go;
  logic             hist_we;
  logic             mac_busy;
  mac_res_t         mac_res;
  logic [DATA_W-1:0] hist_rdata;
  logic [DATA_W-1:0] coef_rdata;

  function automatic logic [HA_W-1:0] prev_base(input logic [HA_W-1:0] base);
    prev_base = (base == '0) ? LAST_BASE : base - CH_STEP;
  endfunction

  // config port
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_channels_r <= NCH_REG_W'(1);
      filter_order_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_NUM_CHANNELS: num_channels_r <= cfg_bus.data[NCH_REG_W-1:0];
        CFG_FILTER_ORDER: filter_order_r <= cfg_bus.data[ORD_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat decode
  assign in_bus.ready = (state_r == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign coef_we      = accept && (in_bus.cmd == CMD_COEF) &&
                        (32'(in_bus.coef_index) < COEF_SIZE);
  assign sample_go    = accept && (in_bus.cmd == CMD_SAMPLE);

  always_comb begin
    row_nxt   = in_bus.restart ? '0 : cnt_r;
    vseen_eff = in_bus.restart ? '0 : vseen_r;
    if (num_channels_r == '0) begin
      nch_nxt = NCH_W'(1);
    end else if (32'(num_channels_r) > MAX_CHANNELS) begin
      nch_nxt = NCH_W'(MAX_CHANNELS);
    end else begin
      nch_nxt = NCH_W'(num_channels_r);
    end
    if (32'(filter_order_r) > MAX_ORDER) begin
      ord_nxt = ORD_W'(MAX_ORDER);
    end else begin
      ord_nxt = ORD_W'(filter_order_r);
    end
    lags_nxt = (ord_nxt < vseen_eff) ? ord_nxt : vseen_eff;
    last_nxt = (32'(row_nxt) + 1) >= 32'(nch_nxt);
  end

  assign issue   = (state_r == S_RUN);
  assign c_last  = (32'(c_r) + 1) == 32'(nch_r);
  assign k_last  = (k_r == lags_r);
  assign done_go = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);
  assign hist_we = done_go;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sample_go) begin
          state_nxt = (lags_nxt == '0) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        if (c_last && k_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !mac_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (done_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_base_r <= '0;
      cnt_r       <= '0;
      vseen_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= issue;
      if (sample_go) begin
        cnt_r   <= row_nxt;
        vseen_r <= vseen_eff;
      end
      if (done_go) begin
        if (last_r) begin
          cnt_r       <= '0;
          head_base_r <= (head_base_r == LAST_BASE) ? '0 : head_base_r + CH_STEP;
          if (32'(vseen_r) < MAX_ORDER) begin
            vseen_r <= vseen_r + ORD_W'(1);
          end
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-sample context and read address walk
  always_ff @(posedge clk) begin
    if (sample_go) begin
      nch_r       <= nch_nxt;
      lags_r      <= lags_nxt;
      row_r       <= row_nxt;
      last_r      <= last_nxt;
      x_r         <= in_bus.sample;
      c_r         <= '0;
      k_r         <= ORD_W'(1);
      hist_base_r <= prev_base(head_base_r);
      coef_lag_r  <= CA_W'(row_nxt);
      coef_addr_r <= CA_W'(row_nxt);
    end else if (issue) begin
      if (c_last) begin
        c_r         <= '0;
        k_r         <= k_r + ORD_W'(1);
        hist_base_r <= prev_base(hist_base_r);
        coef_lag_r  <= coef_lag_r + LAG_STEP;
        coef_addr_r <= coef_lag_r + LAG_STEP;
      end else begin
        c_r         <= c_r + CNT_W'(1);
        coef_addr_r <= coef_addr_r + COL_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_filtered_r <= mac_res.filtered;
      out_clipped_r  <= mac_res.clipped;
      out_channel_r  <= CH_W'(row_r);
      out_end_r      <= last_r;
    end
  end

  vmaf_ram #(
    .DEPTH (COEF_SIZE),
    .WIDTH (DATA_W),
    .AW    (CA_W)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CA_W'(in_bus.coef_index)),
    .wdata (in_bus.coef_value),
    .re    (issue),
    .raddr (coef_addr_r),
    .rdata (coef_rdata)
  );

  vmaf_ram #(
    .DEPTH (RING_SIZE),
    .WIDTH (DATA_W),
    .AW    (HA_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (head_base_r + HA_W'(row_r)),
    .wdata (x_r),
    .re    (issue),
    .raddr (hist_base_r + HA_W'(c_r)),
    .rdata (hist_rdata)
  );

  vmaf_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (sample_go),
    .init_sample (in_bus.sample),
    .vld         (rd_vld_r),
    .hist        (hist_rdata),
    .coef        (coef_rdata),
    .busy        (mac_busy),
    .res         (mac_res)
  );

  assign out_bus.valid      = out_valid_r;
  assign out_bus.filtered   = out_filtered_r;
  assign out_bus.channel    = out_channel_r;
  assign out_bus.vector_end = out_end_r;
  assign out_bus.clipped    = out_clipped_r;

  `VMAF_ASSERT_IMPL(a_coef_addr_range, clk, rst_n, state_r == S_RUN, 32'(coef_addr_r) < COEF_SIZE)
  `VMAF_ASSERT_IMPL(a_done_drained, clk, rst_n, state_r == S_DONE, !rd_vld_r && !mac_busy)
  `VMAF_ASSERT_NEXT(a_passthru_done, clk, rst_n, sample_go && (lags_nxt == '0), state_r == S_DONE)
  `VMAF_ASSERT_IMPL(a_vseen_bound, clk, rst_n, 1'b1, 32'(vseen_r) <= MAX_ORDER)

endmodule
